/* design/bdl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared types and constants for the button debounce and rotary count block.
// ----------------------------------------------------------------------------
package bdl_pkg;

    localparam int TIMER_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;
    localparam int STAMP_W   = 32;

    localparam int ENC0_A = 7;
    localparam int ENC0_B = 8;
    localparam int ENC1_A = 10;
    localparam int ENC1_B = 11;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_TAKE_DOWN = 3'd1,
        CMD_TAKE_UP   = 3'd2,
        CMD_CLEAR     = 3'd3,
        CMD_TAKE_ROT  = 3'd4,
        CMD_RESTAMP   = 3'd5
    } bdl_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_ROTARY_ENABLE  = 2'd1
    } bdl_reg_idx_t;

    typedef struct packed {
        logic               tick;
        logic [TIMER_W-1:0] start;
    } bdl_tick_ctrl_t;

endpackage
`default_nettype wire

/* design/bdl_pins.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdl_pins
// Per-pin debounce countdowns, edge reference and reported levels.
// ----------------------------------------------------------------------------
module bdl_pins #(
    parameter int NUM_BUTTONS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire bdl_pkg::bdl_tick_ctrl_t ctrl,
    input  wire logic [NUM_BUTTONS-1:0] levels,
    output logic [NUM_BUTTONS-1:0]      reported,
    output logic [NUM_BUTTONS-1:0]      reported_next,
    output logic [NUM_BUTTONS-1:0]      changed,
    output logic                        busy_next
);
    import bdl_pkg::*;

    logic [TIMER_W-1:0]     timer_reg [NUM_BUTTONS];
    logic [TIMER_W-1:0]     timer_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] reported_reg;
    logic [NUM_BUTTONS-1:0] edge_ref_reg;
    logic [NUM_BUTTONS-1:0] edge_ref_next;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            timer_next[i] = timer_reg[i];
            changed[i]    = 1'b0;
            if (ctrl.tick) begin
                if (timer_reg[i] != '0) begin
                    timer_next[i] = timer_reg[i] - 1'b1;
                    if ((timer_reg[i] == TIMER_W'(1)) && (levels[i] != reported_reg[i])) begin
                        changed[i] = 1'b1;
                    end
                end else if (levels[i] != edge_ref_reg[i]) begin
                    timer_next[i] = ctrl.start;
                end
            end
        end
    end

    always_comb begin
        busy_next = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (timer_next[i] != '0) begin
                busy_next = 1'b1;
            end
        end
    end

    assign reported_next = reported_reg ^ changed;
    assign edge_ref_next = ctrl.tick ? levels : edge_ref_reg;
    assign reported      = reported_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reported_reg <= '1;
            edge_ref_reg <= '1;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                timer_reg[i] <= '0;
            end
        end else begin
            reported_reg <= reported_next;
            edge_ref_reg <= edge_ref_next;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                timer_reg[i] <= timer_next[i];
            end
        end
    end

endmodule
`default_nettype wire

/* design/button_debounce_latch_rotary_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_latch_rotary_unit
// Debounced button bank with press and release latches, change time stamp
// and two saturating quadrature rotation counts.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Contents
// s_        in         s_valid / s_ready      command, pin levels, encoder select
// m_        out        m_valid / m_ready      masks, rotation, stamp, busy flag
// cfg_      in         cfg_valid / cfg_ready  register index and write data
//
// A request waits in the input register until the result register can take it,
// then is loaded there, which raises m_valid.
// One request per cycle is sustained while m_ready stays high; the input
// register and the result register form a two-deep pipeline.
// s_ready falls only when both registers hold a request and m_ready is low.
// Reset is synchronous on aresetn; request and result data are not reset.
// ----------------------------------------------------------------------------
module button_debounce_latch_rotary_unit #(
    parameter int NUM_BUTTONS = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_command,
    input  wire logic [NUM_BUTTONS-1:0]            s_pin_levels,
    input  wire logic                              s_encoder_select,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [NUM_BUTTONS-1:0]                 m_pressed_mask,
    output logic [NUM_BUTTONS-1:0]                 m_change_mask,
    output logic [NUM_BUTTONS-1:0]                 m_latch_mask,
    output logic signed [COUNT_WIDTH-1:0]          m_rotation_value,
    output logic [bdl_pkg::STAMP_W-1:0]            m_last_change_ms,
    output logic                                   m_debouncing,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bdl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bdl_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import bdl_pkg::*;

    logic [TIMER_W-1:0]     debounce_ticks_reg;
    logic                   rotary_enable_reg;

    logic                   in_vld_reg;
    bdl_cmd_t               in_cmd_reg;
    logic [NUM_BUTTONS-1:0] in_levels_reg;
    logic                   in_sel_reg;

    logic [NUM_BUTTONS-1:0] press_reg, press_next;
    logic [NUM_BUTTONS-1:0] release_reg, release_next;
    logic signed [COUNT_WIDTH-1:0] count_reg [2];
    logic signed [COUNT_WIDTH-1:0] count_next [2];
    logic signed [COUNT_WIDTH:0]   sum_w [2];
    logic signed [COUNT_WIDTH-1:0] sat_w [2];
    logic [STAMP_W-1:0]     tick_reg, tick_next;
    logic [STAMP_W-1:0]     stamp_reg, stamp_next;

    logic                   m_valid_reg, m_valid_next;
    logic [NUM_BUTTONS-1:0] change_out, latch_out;
    logic signed [COUNT_WIDTH-1:0] rot_out;

    logic                   adv;
    logic                   go;
    bdl_tick_ctrl_t         tick_ctrl;
    logic [NUM_BUTTONS-1:0] reported, reported_next, changed, press_new;
    logic                   busy_next;
    logic [1:0]             enc_press, enc_b_prior;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = !in_vld_reg || adv;
    assign go        = in_vld_reg && adv;
    assign cfg_ready = 1'b1;

    assign tick_ctrl.tick  = go && (in_cmd_reg == CMD_TICK);
    assign tick_ctrl.start = (debounce_ticks_reg == '0) ? TIMER_W'(1) : debounce_ticks_reg;

    bdl_pins #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_pins (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (tick_ctrl),
        .levels        (in_levels_reg),
        .reported      (reported),
        .reported_next (reported_next),
        .changed       (changed),
        .busy_next     (busy_next)
    );

    assign press_new = changed & ~in_levels_reg;

    generate
        if (NUM_BUTTONS > ENC0_B) begin : g_enc0
            assign enc_press[0]   = press_new[ENC0_A];
            assign enc_b_prior[0] = reported[ENC0_B];
        end else begin : g_no_enc0
            assign enc_press[0]   = 1'b0;
            assign enc_b_prior[0] = 1'b0;
        end
        if (NUM_BUTTONS > ENC1_B) begin : g_enc1
            assign enc_press[1]   = press_new[ENC1_A];
            assign enc_b_prior[1] = reported[ENC1_B];
        end else begin : g_no_enc1
            assign enc_press[1]   = 1'b0;
            assign enc_b_prior[1] = 1'b0;
        end
    endgenerate

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            sum_w[e] = {count_reg[e][COUNT_WIDTH-1], count_reg[e]}
                     + (enc_b_prior[e] ? {(COUNT_WIDTH+1){1'b1}} : (COUNT_WIDTH+1)'(1));
            if (sum_w[e][COUNT_WIDTH] != sum_w[e][COUNT_WIDTH-1]) begin
                sat_w[e] = sum_w[e][COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                                                 : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
            end else begin
                sat_w[e] = sum_w[e][COUNT_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        press_next    = press_reg;
        release_next  = release_reg;
        count_next[0] = count_reg[0];
        count_next[1] = count_reg[1];
        tick_next     = tick_reg;
        stamp_next    = stamp_reg;
        change_out    = '0;
        latch_out     = '0;
        rot_out       = '0;
        if (go) begin
            case (in_cmd_reg)
                CMD_TICK: begin
                    tick_next    = tick_reg + 1'b1;
                    change_out   = changed;
                    press_next   = press_reg | press_new;
                    release_next = release_reg | (changed & in_levels_reg);
                    for (int e = 0; e < 2; e++) begin
                        if (rotary_enable_reg && enc_press[e]) begin
                            count_next[e] = sat_w[e];
                        end
                    end
                    if (changed != '0) begin
                        stamp_next = tick_reg + 1'b1;
                    end
                end
                CMD_TAKE_DOWN: begin
                    latch_out  = press_reg;
                    press_next = '0;
                end
                CMD_TAKE_UP: begin
                    latch_out    = release_reg;
                    release_next = '0;
                end
                CMD_CLEAR: begin
                    press_next   = '0;
                    release_next = '0;
                end
                CMD_TAKE_ROT: begin
                    rot_out                = count_reg[in_sel_reg];
                    count_next[in_sel_reg] = '0;
                end
                CMD_RESTAMP: begin
                    stamp_next = tick_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg <= TIMER_W'(3);
            rotary_enable_reg  <= 1'b1;
            in_vld_reg         <= 1'b0;
            m_valid_reg        <= 1'b0;
            press_reg          <= '0;
            release_reg        <= '0;
            count_reg[0]       <= '0;
            count_reg[1]       <= '0;
            tick_reg           <= '0;
            stamp_reg          <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[TIMER_W-1:0];
                    REG_ROTARY_ENABLE:  rotary_enable_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            m_valid_reg  <= m_valid_next;
            press_reg    <= press_next;
            release_reg  <= release_next;
            count_reg[0] <= count_next[0];
            count_reg[1] <= count_next[1];
            tick_reg     <= tick_next;
            stamp_reg    <= stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= bdl_cmd_t'(s_command);
            in_levels_reg <= s_pin_levels;
            in_sel_reg    <= s_encoder_select;
        end
        if (go) begin
            m_pressed_mask   <= ~reported_next;
            m_change_mask    <= change_out;
            m_latch_mask     <= latch_out;
            m_rotation_value <= rot_out;
            m_last_change_ms <= stamp_next;
            m_debouncing     <= busy_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_stamp_follows_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_ctrl.tick && (changed != '0)) |=> (m_last_change_ms == tick_reg))
        else $error("change stamp does not match the tick count");

    a_change_latch_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_change_mask == '0) || (m_latch_mask == '0)))
        else $error("change mask and latch mask both set in one result");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && m_valid_reg && !m_ready))
        else $error("input stalled while the pipeline can advance");

    a_rotation_only_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_rotation_value != '0)) |-> (m_change_mask == '0))
        else $error("rotation value reported together with a level change");

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button debounce, latch and rotary count unit.
// A short table of directed requests is followed by random button activity
// with contact bounce under several register settings, and by a short encoder
// sweep that turns both rotation counts in opposite directions. Both channels
// idle at random. Every result is checked field by field against a fixed report for typed
// directed rows or else an in-bench prediction, kept in order in a queue of awaited reports.
// ----------------------------------------------------------------------------
module tb;
    import bdl_pkg::*;

    localparam int NUM_PINS     = 12;
    localparam int ROT_W        = 16;
    localparam int ROT_MAX      = 2 ** (ROT_W - 1) - 1;
    localparam int ROT_MIN      = -(2 ** (ROT_W - 1));
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 212;
    localparam int SWEEP_TURNS  = 8;
    localparam int RESET_TICKS  = 3;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [NUM_PINS-1:0] ALL_RELEASED = '1;
    localparam logic [NUM_PINS-1:0] SWEEP_UP     = ALL_RELEASED & ~(NUM_PINS'(1) << ENC1_B);
    localparam logic [NUM_PINS-1:0] SWEEP_DOWN   =
        SWEEP_UP & ~(NUM_PINS'(1) << ENC0_A) & ~(NUM_PINS'(1) << ENC1_A);

    typedef struct packed {
        logic [NUM_PINS-1:0]     pressed_mask;
        logic [NUM_PINS-1:0]     change_mask;
        logic [NUM_PINS-1:0]     latch_mask;
        logic signed [ROT_W-1:0] rotation_value;
        logic [STAMP_W-1:0]      last_change_ms;
        logic                    debouncing;
    } button_report_t;

    typedef struct {
        logic [2:0]          command;
        logic [NUM_PINS-1:0] levels;
        logic                encoder_select;
        int                  repeats;
        bit                  typed;
        button_report_t      want;
    } request_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [2:0]                  s_command;
    logic [NUM_PINS-1:0]         s_pin_levels;
    logic                        s_encoder_select;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [NUM_PINS-1:0]         m_pressed_mask;
    logic [NUM_PINS-1:0]         m_change_mask;
    logic [NUM_PINS-1:0]         m_latch_mask;
    logic signed [ROT_W-1:0]     m_rotation_value;
    logic [STAMP_W-1:0]          m_last_change_ms;
    logic                        m_debouncing;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DAT_W-1:0]        cfg_data;

    // Predicted state of the block and its registers.
    logic [TIMER_W-1:0]          set_ticks;
    logic                        set_rotary;
    logic [NUM_PINS-1:0]         shown_levels;
    logic [NUM_PINS-1:0]         last_levels;
    logic [NUM_PINS-1:0]         down_latched;
    logic [NUM_PINS-1:0]         up_latched;
    logic [TIMER_W-1:0]          countdown [NUM_PINS];
    logic signed [ROT_W-1:0]     turn_tally [2];
    logic [STAMP_W-1:0]          ms_count;
    logic [STAMP_W-1:0]          change_time;

    button_report_t              awaited_reports [$];
    request_row_t                directed_rows [$];
    button_report_t              head_report;
    logic [NUM_PINS-1:0]         contact_levels;
    logic                        hold_off = 1'b0;
    bit                          tx_steady;
    bit                          rx_steady;
    bit                          sweep_on;
    int                          rx_wait;
    int                          items_sent;
    int                          mismatches;
    int                          cycle_count = 0;

    button_debounce_latch_rotary_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pin_levels     (s_pin_levels),
        .s_encoder_select (s_encoder_select),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pressed_mask   (m_pressed_mask),
        .m_change_mask    (m_change_mask),
        .m_latch_mask     (m_latch_mask),
        .m_rotation_value (m_rotation_value),
        .m_last_change_ms (m_last_change_ms),
        .m_debouncing     (m_debouncing),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_prediction();
        int i;
        set_ticks      = TIMER_W'(RESET_TICKS);
        set_rotary     = 1'b1;
        shown_levels   = '1;
        last_levels    = '1;
        down_latched   = '0;
        up_latched     = '0;
        for (i = 0; i < NUM_PINS; i++) countdown[i] = '0;
        turn_tally[0] = '0;
        turn_tally[1] = '0;
        ms_count       = '0;
        change_time    = '0;
    endfunction

    function automatic button_report_t predict_report(input logic [2:0] command,
                                                      input logic [NUM_PINS-1:0] levels,
                                                      input logic sel);
        button_report_t      rep;
        logic [NUM_PINS-1:0] prior;
        logic [TIMER_W-1:0]  start;
        int                  i;
        int                  enc;
        int                  bpin;
        int                  sum;
        rep = '0;
        case (command)
            CMD_TICK: begin
                prior = shown_levels;
                start = (set_ticks == '0) ? TIMER_W'(1) : set_ticks;
                ms_count = ms_count + 1;
                for (i = 0; i < NUM_PINS; i++) begin
                    if (countdown[i] != '0) begin
                        countdown[i] = countdown[i] - 1'b1;
                        if (countdown[i] == '0 && levels[i] != shown_levels[i]) begin
                            shown_levels[i] = levels[i];
                            rep.change_mask[i] = 1'b1;
                            if (levels[i]) begin
                                up_latched[i] = 1'b1;
                            end else begin
                                down_latched[i] = 1'b1;
                                if (set_rotary && (i == ENC0_A || i == ENC1_A)) begin
                                    enc  = (i == ENC0_A) ? 0 : 1;
                                    bpin = (i == ENC0_A) ? ENC0_B : ENC1_B;
                                    sum  = int'(turn_tally[enc]) + (prior[bpin] ? -1 : 1);
                                    if (sum > ROT_MAX) sum = ROT_MAX;
                                    if (sum < ROT_MIN) sum = ROT_MIN;
                                    turn_tally[enc] = ROT_W'(sum);
                                end
                            end
                        end
                    end else if (levels[i] != last_levels[i]) begin
                        countdown[i] = start;
                    end
                end
                last_levels = levels;
                if (rep.change_mask != '0) change_time = ms_count;
            end
            CMD_TAKE_DOWN: begin
                rep.latch_mask = down_latched;
                down_latched = '0;
            end
            CMD_TAKE_UP: begin
                rep.latch_mask = up_latched;
                up_latched = '0;
            end
            CMD_CLEAR: begin
                down_latched = '0;
                up_latched = '0;
            end
            CMD_TAKE_ROT: begin
                rep.rotation_value = turn_tally[sel];
                turn_tally[sel] = '0;
            end
            CMD_RESTAMP: begin
                change_time = ms_count;
            end
            default: begin
            end
        endcase
        rep.pressed_mask   = ~shown_levels;
        rep.last_change_ms = change_time;
        for (i = 0; i < NUM_PINS; i++) begin
            if (countdown[i] != '0) rep.debouncing = 1'b1;
        end
        return rep;
    endfunction

    task automatic stage_row(input logic [2:0] command, input logic [NUM_PINS-1:0] levels,
                             input logic sel, input int repeats, input bit typed,
                             input button_report_t want);
        request_row_t row;
        row.command        = command;
        row.levels         = levels;
        row.encoder_select = sel;
        row.repeats        = repeats;
        row.typed          = typed;
        row.want           = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input logic [2:0] command, input logic [NUM_PINS-1:0] levels,
                                input logic sel, input bit typed, input button_report_t want);
        int             gap;
        button_report_t predicted;
        gap = (sweep_on || tx_steady) ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= command;
        s_pin_levels     <= levels;
        s_encoder_select <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_report(command, levels, sel);
        awaited_reports.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // The block is idle once every awaited report is in and the pipeline has run dry.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            REG_DEBOUNCE_TICKS: set_ticks = data[TIMER_W-1:0];
            REG_ROTARY_ENABLE:  set_rotary = data[0];
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Buttons change now and then; a tick sees the contacts, sometimes with bounce on top.
    task automatic random_request(output logic [2:0] command, output logic [NUM_PINS-1:0] levels,
                                  output logic sel);
        int pick;
        int pin;
        pick   = $urandom_range(0, 99);
        sel    = 1'($urandom_range(0, 1));
        levels = NUM_PINS'($urandom);
        if (pick < 70) begin
            command = CMD_TICK;
            if ($urandom_range(0, 7) == 0) begin
                pin = $urandom_range(0, NUM_PINS - 1);
                contact_levels[pin] = ~contact_levels[pin];
            end
            if ($urandom_range(0, 31) == 0) begin
                levels = NUM_PINS'($urandom);
            end else if ($urandom_range(0, 3) == 0) begin
                levels = contact_levels ^ (NUM_PINS'($urandom) & NUM_PINS'($urandom)
                                           & NUM_PINS'($urandom));
            end else begin
                levels = contact_levels;
            end
        end else if (pick < 76) begin
            command = CMD_TAKE_DOWN;
        end else if (pick < 82) begin
            command = CMD_TAKE_UP;
        end else if (pick < 86) begin
            command = CMD_CLEAR;
        end else if (pick < 93) begin
            command = CMD_TAKE_ROT;
        end else if (pick < 97) begin
            command = CMD_RESTAMP;
        end else begin
            command = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        end
    endtask

    initial begin : stimulus
        button_report_t      quiet;
        button_report_t      busy_now;
        logic [2:0]          cmd;
        logic [NUM_PINS-1:0] lv;
        logic                sel;
        logic [TIMER_W-1:0]  ticks;
        logic                rotary;
        int                  phase;
        int                  k;
        aresetn          <= 1'b0;
        s_valid          <= 1'b0;
        s_command        <= CMD_TICK;
        s_pin_levels     <= '1;
        s_encoder_select <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= REG_DEBOUNCE_TICKS;
        cfg_data         <= '0;
        clear_prediction();
        contact_levels = '1;
        quiet = '0;
        busy_now = '0;
        busy_now.debouncing = 1'b1;

        stage_row(CMD_TAKE_DOWN, '0, 1'b0, 1, 1'b1, quiet);
        stage_row(CMD_SPARE_LO, '0, 1'b0, 1, 1'b1, quiet);
        stage_row(CMD_SPARE_HI, '1, 1'b1, 1, 1'b1, quiet);
        stage_row(CMD_RESTAMP, '0, 1'b0, 1, 1'b1, quiet);
        stage_row(CMD_TICK, '0, 1'b0, 1, 1'b1, busy_now);
        // All pins pressed at once, so each encoder sees its B pin still released.
        stage_row(CMD_TICK, '0, 1'b0, 3, 1'b0, quiet);
        stage_row(CMD_TAKE_DOWN, '1, 1'b1, 1, 1'b0, quiet);
        stage_row(CMD_TAKE_ROT, '0, 1'b0, 1, 1'b0, quiet);
        stage_row(CMD_TICK, NUM_PINS'(1) << ENC0_A, 1'b0, 4, 1'b0, quiet);
        stage_row(CMD_TICK, '0, 1'b0, 4, 1'b0, quiet);
        stage_row(CMD_TAKE_ROT, '0, 1'b0, 1, 1'b0, quiet);
        stage_row(CMD_TICK, '1, 1'b0, 4, 1'b0, quiet);
        stage_row(CMD_TAKE_UP, '0, 1'b0, 1, 1'b0, quiet);
        stage_row(CMD_CLEAR, '0, 1'b0, 1, 1'b0, quiet);
        stage_row(CMD_RESTAMP, '1, 1'b0, 1, 1'b0, quiet);
        stage_row(CMD_TAKE_ROT, '0, 1'b1, 1, 1'b0, quiet);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[n]) begin
            repeat (directed_rows[n].repeats) begin
                send_request(directed_rows[n].command, directed_rows[n].levels,
                             directed_rows[n].encoder_select, directed_rows[n].typed,
                             directed_rows[n].want);
            end
        end
        settle_block();

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin ticks = TIMER_W'(1);  rotary = 1'b1; end
                1: begin ticks = TIMER_W'(15); rotary = 1'b0; end
                2: begin ticks = TIMER_W'(0);  rotary = 1'b1; end
                default: begin
                    ticks  = TIMER_W'($urandom_range(0, 15));
                    rotary = 1'($urandom_range(0, 1));
                end
            endcase
            write_register(REG_DEBOUNCE_TICKS, CFG_DAT_W'(ticks));
            write_register(REG_ROTARY_ENABLE, {3'($urandom_range(0, 7)), rotary});
            if (phase == 3) begin
                write_register(REG_SPARE_LO, CFG_DAT_W'($urandom));
                write_register(REG_SPARE_HI, CFG_DAT_W'($urandom));
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                random_request(cmd, lv, sel);
                send_request(cmd, lv, sel, 1'b0, quiet);
            end
            settle_block();
        end

        // Encoder 0 turns down with B released, encoder 1 turns up with B held pressed.
        write_register(REG_DEBOUNCE_TICKS, CFG_DAT_W'(1));
        write_register(REG_ROTARY_ENABLE, CFG_DAT_W'(1));
        sweep_on = 1'b1;
        send_request(CMD_TAKE_ROT, SWEEP_UP, 1'b0, 1'b0, quiet);
        send_request(CMD_TAKE_ROT, SWEEP_UP, 1'b1, 1'b0, quiet);
        repeat (20) send_request(CMD_TICK, SWEEP_UP, 1'b0, 1'b0, quiet);
        repeat (SWEEP_TURNS) begin
            repeat (2) send_request(CMD_TICK, SWEEP_DOWN, 1'b0, 1'b0, quiet);
            repeat (2) send_request(CMD_TICK, SWEEP_UP, 1'b0, 1'b0, quiet);
        end
        send_request(CMD_TAKE_ROT, SWEEP_UP, 1'b0, 1'b0, quiet);
        send_request(CMD_TAKE_ROT, SWEEP_UP, 1'b1, 1'b0, quiet);
        send_request(CMD_CLEAR, SWEEP_UP, 1'b0, 1'b0, quiet);
        settle_block();
        sweep_on = 1'b0;

        if (mismatches == 0 && awaited_reports.size() == 0) begin
            $display("button_debounce_latch_rotary_unit verification clean");
        end else begin
            $display("button_debounce_latch_rotary_unit verification failed");
        end
        $finish;
    end

    // The receiver stops taking results for a long stretch while requests keep coming.
    initial begin : receiver_hold_off
        wait (items_sent >= 600);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%s pressed %h change %h latch %h rot %0d stamp %0d busy %b",
                                 "unexpected result:",
                                 m_pressed_mask, m_change_mask, m_latch_mask, m_rotation_value,
                                 m_last_change_ms, m_debouncing);
                    end
                end else begin
                    head_report = awaited_reports.pop_front();
                    if (m_pressed_mask !== head_report.pressed_mask
                        || m_change_mask !== head_report.change_mask
                        || m_latch_mask !== head_report.latch_mask
                        || m_rotation_value !== head_report.rotation_value
                        || m_last_change_ms !== head_report.last_change_ms
                        || m_debouncing !== head_report.debouncing) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%s pressed %h change %h latch %h rot %0d stamp %0d busy %b",
                                     "mismatch expected:",
                                     head_report.pressed_mask, head_report.change_mask,
                                     head_report.latch_mask, head_report.rotation_value,
                                     head_report.last_change_ms, head_report.debouncing);
                            $display("%s pressed %h change %h latch %h rot %0d stamp %0d busy %b",
                                     "         actual:  ",
                                     m_pressed_mask, m_change_mask, m_latch_mask,
                                     m_rotation_value, m_last_change_ms, m_debouncing);
                        end
                    end
                end
                rx_wait = (sweep_on || rx_steady) ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
            end else if (m_valid && rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            m_ready <= (rx_wait == 0) && !hold_off;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("button_debounce_latch_rotary_unit verification failed");
            $finish;
        end
    end

endmodule
